@@ design/tcnc_pkg.sv @@
// ----------------------------------------------------------------------------
// tcnc_pkg
// shared types, constants and character helpers for the code converter
// ----------------------------------------------------------------------------
package tcnc_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned NumInW  = 32;
  localparam int unsigned NumOutW = 16;
  localparam int unsigned IdxW    = 6;

  localparam int unsigned Base36Start = 4096;
  localparam int unsigned Base36Last  = 30015;
  localparam int unsigned Base41Start = 46656;
  localparam int unsigned Base41Last  = 55060;

  // reciprocal constants for exact division of values below 2^15
  localparam int unsigned RecipShift = 28;
  localparam longint unsigned Recip36   = ((64'd1 << RecipShift) + 64'd35) / 64'd36;
  localparam longint unsigned Recip41   = ((64'd1 << RecipShift) + 64'd40) / 64'd41;
  localparam longint unsigned Recip1296 = ((64'd1 << RecipShift) + 64'd1295) / 64'd1296;
  localparam longint unsigned Recip1681 = ((64'd1 << RecipShift) + 64'd1680) / 64'd1681;

  localparam logic ReqDecode = 1'b0;
  localparam logic ReqEncode = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [CharW-1:0] code_char_first;
    logic [CharW-1:0] code_char_middle;
    logic [CharW-1:0] code_char_last;
    logic [NumInW-1:0] number_in;
  } tcnc_req_t;

  typedef struct packed {
    logic [NumOutW-1:0] decoded_number;
    logic [CharW-1:0]   out_char_first;
    logic [CharW-1:0]   out_char_middle;
    logic [CharW-1:0]   out_char_last;
    logic               code_valid;
  } tcnc_res_t;

  typedef struct packed {
    logic            ok;
    logic [IdxW-1:0] idx;
  } tcnc_sym_t;

  // symbol index of a character in the 41-symbol alphabet, case-insensitive
  function automatic tcnc_sym_t sym_index(input logic [CharW-1:0] c);
    logic [CharW-1:0] v;
    tcnc_sym_t        s;
    v = c;
    if (c >= "A" && c <= "Z") begin
      v = c + 8'd32;
    end
    s.ok  = 1'b1;
    s.idx = '0;
    if (v >= "0" && v <= "9") begin
      s.idx = IdxW'(v - "0");
    end else if (v >= "a" && v <= "z") begin
      s.idx = IdxW'(v - "a" + 8'd10);
    end else begin
      case (v)
        "_":     s.idx = 6'd36;
        "-":     s.idx = 6'd37;
        "!":     s.idx = 6'd38;
        "@":     s.idx = 6'd39;
        "%":     s.idx = 6'd40;
        default: s.ok  = 1'b0;
      endcase
    end
    return s;
  endfunction

  // character for a symbol index, lowercase letters
  function automatic logic [CharW-1:0] sym_char(input logic [IdxW-1:0] idx);
    logic [CharW-1:0] ch;
    if (idx < 6'd10) begin
      ch = "0" + CharW'(idx);
    end else if (idx < 6'd36) begin
      ch = "a" + CharW'(idx - 6'd10);
    end else begin
      case (idx)
        6'd36:   ch = "_";
        6'd37:   ch = "-";
        6'd38:   ch = "!";
        6'd39:   ch = "@";
        default: ch = "%";
      endcase
    end
    return ch;
  endfunction

endpackage

@@ design/tcnc_decode.sv @@
// ----------------------------------------------------------------------------
// tcnc_decode
// three characters to number, hex then base-36 then base-41
// ----------------------------------------------------------------------------
module tcnc_decode (
  input  tcnc_pkg::tcnc_req_t req_i,
  output tcnc_pkg::tcnc_res_t res_o
);

  tcnc_pkg::tcnc_sym_t sa, sb, sc;
  logic all_hex, all_36, all_41;
  logic [31:0] num36, num41;

  always_comb begin
    sa = tcnc_pkg::sym_index(req_i.code_char_first);
    sb = tcnc_pkg::sym_index(req_i.code_char_middle);
    sc = tcnc_pkg::sym_index(req_i.code_char_last);

    all_41  = sa.ok && sb.ok && sc.ok;
    all_36  = all_41 && sa.idx < 6'd36 && sb.idx < 6'd36 && sc.idx < 6'd36;
    all_hex = all_36 && sa.idx < 6'd16 && sb.idx < 6'd16 && sc.idx < 6'd16;

    num36 = 32'(sa.idx - 6'd16) * 32'd1296 + 32'(sb.idx) * 32'd36 + 32'(sc.idx)
          + 32'(tcnc_pkg::Base36Start);
    num41 = 32'(sa.idx - 6'd36) * 32'd1681 + 32'(sb.idx) * 32'd41 + 32'(sc.idx)
          + 32'(tcnc_pkg::Base41Start);

    res_o = '0;
    if (all_hex) begin
      res_o.decoded_number = {4'd0, sa.idx[3:0], sb.idx[3:0], sc.idx[3:0]};
      res_o.code_valid     = 1'b1;
    end else if (all_36) begin
      if (sa.idx >= 6'd16) begin
        res_o.decoded_number = num36[15:0];
        res_o.code_valid     = 1'b1;
      end
    end else if (all_41) begin
      if (sa.idx >= 6'd36) begin
        res_o.decoded_number = num41[15:0];
        res_o.code_valid     = 1'b1;
      end
    end
  end

endmodule

@@ design/tcnc_encode.sv @@
// ----------------------------------------------------------------------------
// tcnc_encode
// number to three characters through reciprocal constant division
// ----------------------------------------------------------------------------
module tcnc_encode (
  input  tcnc_pkg::tcnc_req_t req_i,
  output tcnc_pkg::tcnc_res_t res_o
);

  logic [31:0] x;
  logic        in_hex, in_36, in_41;
  logic [14:0] off36;
  logic [13:0] off41;
  logic [47:0] p36_hi, p36_lo, p41_hi, p41_lo;
  logic [4:0]  q1_36;
  logic [9:0]  q2_36;
  logic [2:0]  q1_41;
  logic [7:0]  q2_41;
  logic [9:0]  mid36;
  logic [14:0] last36;
  logic [7:0]  mid41;
  logic [13:0] last41;

  always_comb begin
    x      = req_i.number_in;
    in_hex = x < 32'(tcnc_pkg::Base36Start);
    in_36  = !in_hex && x <= 32'(tcnc_pkg::Base36Last);
    in_41  = x >= 32'(tcnc_pkg::Base41Start) && x <= 32'(tcnc_pkg::Base41Last);

    off36 = 15'(x[14:0] - 15'(tcnc_pkg::Base36Start));
    off41 = 14'(x[15:0] - 16'(tcnc_pkg::Base41Start));

    // quotients taken directly from the offset, digits by back-multiply
    p36_hi = 48'(off36) * 48'(tcnc_pkg::Recip1296);
    p36_lo = 48'(off36) * 48'(tcnc_pkg::Recip36);
    p41_hi = 48'(off41) * 48'(tcnc_pkg::Recip1681);
    p41_lo = 48'(off41) * 48'(tcnc_pkg::Recip41);

    q1_36 = 5'(p36_hi >> tcnc_pkg::RecipShift);
    q2_36 = 10'(p36_lo >> tcnc_pkg::RecipShift);
    q1_41 = 3'(p41_hi >> tcnc_pkg::RecipShift);
    q2_41 = 8'(p41_lo >> tcnc_pkg::RecipShift);

    mid36  = q2_36 - 10'(q1_36) * 10'd36;
    last36 = off36 - 15'(q2_36) * 15'd36;
    mid41  = q2_41 - 8'(q1_41) * 8'd41;
    last41 = off41 - 14'(q2_41) * 14'd41;

    res_o = '0;
    if (in_hex) begin
      res_o.out_char_first  = tcnc_pkg::sym_char({2'b00, x[11:8]});
      res_o.out_char_middle = tcnc_pkg::sym_char({2'b00, x[7:4]});
      res_o.out_char_last   = tcnc_pkg::sym_char({2'b00, x[3:0]});
      res_o.code_valid      = 1'b1;
    end else if (in_36) begin
      res_o.out_char_first  = tcnc_pkg::sym_char(6'd16 + 6'(q1_36));
      res_o.out_char_middle = tcnc_pkg::sym_char(mid36[5:0]);
      res_o.out_char_last   = tcnc_pkg::sym_char(last36[5:0]);
      res_o.code_valid      = 1'b1;
    end else if (in_41) begin
      res_o.out_char_first  = tcnc_pkg::sym_char(6'd36 + 6'(q1_41));
      res_o.out_char_middle = tcnc_pkg::sym_char(mid41[5:0]);
      res_o.out_char_last   = tcnc_pkg::sym_char(last41[5:0]);
      res_o.code_valid      = 1'b1;
    end else begin
      res_o.out_char_first  = "0";
      res_o.out_char_middle = "0";
      res_o.out_char_last   = "0";
    end
  end

endmodule

@@ design/three_char_number_code_converter.sv @@
// ----------------------------------------------------------------------------
// three_char_number_code_converter
// stream converter between three-character codes and numbers
// ----------------------------------------------------------------------------
// Converts one beat per clock cycle in either direction. A decode beat
// (tuser 0) turns three ASCII characters into a number: three hex digits give
// 0..4095, three base-36 characters with a lead of g..z give 4096..30015, and
// three base-41 characters (0-9, a-z, _ - ! @ %) with a lead from _ - ! @ %
// give 46656..55060; letters are accepted in either case. An encode beat
// (tuser 1) is the inverse and emits lowercase characters. Anything outside
// these ranges returns code_valid 0 with number 0, or "000" for an encode.
// The block takes a new beat every cycle while the master side keeps up;
// an accepted beat passes through one input register, one pass of conversion
// logic (constant multiplies and compares) and one result register.
// Backpressure on the master side stalls each full register in place and
// holds the slave ready low only once both are full.
// ----------------------------------------------------------------------------
module three_char_number_code_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // code_char_first, code_char_middle, code_char_last, number_in
  input  logic [55:0] s_axis_tdata_i,
  // req_type
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // decoded_number, out_char_first, out_char_middle, out_char_last
  output logic [39:0] m_axis_tdata_o,
  // code_valid
  output logic        m_axis_tuser_o
);

  // input register stage
  logic                s1_valid_q, s1_valid_d;
  tcnc_pkg::tcnc_req_t s1_req_q, s1_req_d;
  // result register stage
  logic                out_valid_q, out_valid_d;
  tcnc_pkg::tcnc_res_t out_res_q, out_res_d;

  tcnc_pkg::tcnc_req_t in_req;
  tcnc_pkg::tcnc_res_t dec_res, enc_res;
  logic                out_ready, s1_ready;

  // unpack slave beat
  always_comb begin
    in_req.req_type         = s_axis_tuser_i;
    in_req.code_char_first  = s_axis_tdata_i[7:0];
    in_req.code_char_middle = s_axis_tdata_i[15:8];
    in_req.code_char_last   = s_axis_tdata_i[23:16];
    in_req.number_in        = s_axis_tdata_i[55:24];
  end

  tcnc_decode u_decode (
    .req_i (s1_req_q),
    .res_o (dec_res)
  );

  tcnc_encode u_encode (
    .req_i (s1_req_q),
    .res_o (enc_res)
  );

  // each stage advances when the one after it is empty or draining
  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign s1_ready        = !s1_valid_q || out_ready;
  assign s_axis_tready_o = s1_ready;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_req_d    = s1_req_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (out_ready) begin
      out_valid_d = s1_valid_q;
      out_res_d   = (s1_req_q.req_type == tcnc_pkg::ReqEncode) ? enc_res : dec_res;
    end
    if (s1_ready) begin
      s1_valid_d = s_axis_tvalid_i;
      s1_req_d   = in_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    s1_req_q  <= s1_req_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.out_char_last, out_res_q.out_char_middle,
                            out_res_q.out_char_first, out_res_q.decoded_number};
  assign m_axis_tuser_o  = out_res_q.code_valid;

endmodule

@@ design/tcnc_checker.sv @@
// ----------------------------------------------------------------------------
// tcnc_checker
// port-level checks on the code converter, bound to the top level
// ----------------------------------------------------------------------------
module tcnc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [55:0] s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // an accepted beat reaches the output through the input and result registers when not held off
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("accepted beat did not produce a result");

  // empty output implies the input side is open
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // invalid results carry a zero number, numbers stay in range
  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[15:0] <= 16'd55060) &&
                        (m_axis_tuser_o || m_axis_tdata_o[15:0] == 16'd0))
    else $error("decoded number out of range");

endmodule

bind three_char_number_code_converter tcnc_checker u_tcnc_checker (.*);

@@ tb/code_conv_checker.sv @@
// ----------------------------------------------------------------------------
// code_conv_checker
// watches both stream sides, predicts each conversion and compares results
// ----------------------------------------------------------------------------
module code_conv_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [55:0] s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  localparam string Glyphs = "0123456789abcdefghijklmnopqrstuvwxyz_-!@%";

  tcnc_pkg::tcnc_res_t conv_due[$];

  // position of a character in the 41-symbol alphabet, letters folded to lowercase
  function automatic int glyph_rank(input logic [7:0] c);
    logic [7:0] v;
    v = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    for (int i = 0; i < 41; i++) begin
      if (8'(Glyphs[i]) == v) return i;
    end
    return -1;
  endfunction

  function automatic logic [7:0] glyph_at(input int unsigned r);
    return 8'(Glyphs[r]);
  endfunction

  function automatic tcnc_pkg::tcnc_res_t convert_code(
    input logic is_encode, input logic [7:0] c0, input logic [7:0] c1,
    input logic [7:0] c2, input logic [31:0] num);
    tcnc_pkg::tcnc_res_t r;
    int                  a, b, c;
    int unsigned         x;
    r = '0;
    if (is_encode != tcnc_pkg::ReqEncode) begin
      a = glyph_rank(c0);
      b = glyph_rank(c1);
      c = glyph_rank(c2);
      if (a >= 0 && a < 16 && b >= 0 && b < 16 && c >= 0 && c < 16) begin
        r.decoded_number = 16'(a * 256 + b * 16 + c);
        r.code_valid     = 1'b1;
      end else if (a >= 0 && a < 36 && b >= 0 && b < 36 && c >= 0 && c < 36) begin
        if (a >= 16) begin
          r.decoded_number = 16'(tcnc_pkg::Base36Start + (a - 16) * 1296 + b * 36 + c);
          r.code_valid     = 1'b1;
        end
      end else if (a >= 0 && b >= 0 && c >= 0) begin
        if (a >= 36) begin
          r.decoded_number = 16'(tcnc_pkg::Base41Start + (a - 36) * 1681 + b * 41 + c);
          r.code_valid     = 1'b1;
        end
      end
    end else begin
      x            = num;
      r.code_valid = 1'b1;
      if (x < tcnc_pkg::Base36Start) begin
        r.out_char_first  = glyph_at((x >> 8) & 15);
        r.out_char_middle = glyph_at((x >> 4) & 15);
        r.out_char_last   = glyph_at(x & 15);
      end else if (x <= tcnc_pkg::Base36Last) begin
        x -= tcnc_pkg::Base36Start;
        r.out_char_first  = glyph_at(16 + x / 1296);
        r.out_char_middle = glyph_at((x % 1296) / 36);
        r.out_char_last   = glyph_at(x % 36);
      end else if (x >= tcnc_pkg::Base41Start && x <= tcnc_pkg::Base41Last) begin
        x -= tcnc_pkg::Base41Start;
        r.out_char_first  = glyph_at(36 + x / 1681);
        r.out_char_middle = glyph_at((x % 1681) / 41);
        r.out_char_last   = glyph_at(x % 41);
      end else begin
        r.out_char_first  = "0";
        r.out_char_middle = "0";
        r.out_char_last   = "0";
        r.code_valid      = 1'b0;
      end
    end
    return r;
  endfunction

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  always @(posedge clk_i) begin
    tcnc_pkg::tcnc_res_t want, got;
    if (rst_ni) begin
      // result side first: a beat entering now cannot leave in the same cycle
      if (m_tvalid_i && m_tready_i) begin
        got.decoded_number  = m_tdata_i[15:0];
        got.out_char_first  = m_tdata_i[23:16];
        got.out_char_middle = m_tdata_i[31:24];
        got.out_char_last   = m_tdata_i[39:32];
        got.code_valid      = m_tuser_i;
        if (conv_due.size() == 0) begin
          $display("%0t: unexpected result beat, actual %h", $realtime, got);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = conv_due.pop_front();
          if (got.decoded_number  !== want.decoded_number  ||
              got.out_char_first  !== want.out_char_first  ||
              got.out_char_middle !== want.out_char_middle ||
              got.out_char_last   !== want.out_char_last   ||
              got.code_valid      !== want.code_valid) begin
            $display("%0t: mismatch expected %0d '%s%s%s' %b, actual %0d '%s%s%s' %b",
                     $realtime, want.decoded_number, want.out_char_first,
                     want.out_char_middle, want.out_char_last, want.code_valid,
                     got.decoded_number, got.out_char_first, got.out_char_middle,
                     got.out_char_last, got.code_valid);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        conv_due.push_back(convert_code(s_tuser_i, s_tdata_i[7:0], s_tdata_i[15:8],
                                        s_tdata_i[23:16], s_tdata_i[55:24]));
      end
      pending_o <= conv_due.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the three-character code converter
// ----------------------------------------------------------------------------
// Drives directed corner codes and numbers, then about four hundred random
// decode and encode beats under three idling profiles, with one long result
// stall and drain pauses in between. A separate checker predicts every
// result and counts mismatches; this module only makes traffic and decides.
// ----------------------------------------------------------------------------
module testbench;

  localparam int    HoldCycles    = 200;   // long receiver hold-off
  localparam int    WatchdogLimit = 3000;  // cycles with no beat on either side
  localparam int    TailCycles    = 8;     // settle after the last result
  localparam int    PhaseItems    = 135;
  localparam string Glyphs        = "0123456789abcdefghijklmnopqrstuvwxyz_-!@%";

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;   // code_char_first, code_char_middle, code_char_last, number_in
  logic        s_tuser;   // req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // decoded_number, out_char_first, out_char_middle, out_char_last
  logic        m_tuser;   // code_valid
  int          fail_cnt;
  int          pending;

  int          src_idle_pct;
  int          sink_idle_pct;
  logic        hold_req;

  // 8-unit clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  three_char_number_code_converter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  code_conv_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // symbol of the alphabet at a random rank from lo to hi, letters in random case
  function automatic logic [7:0] pick_glyph(input int unsigned lo, input int unsigned hi);
    logic [7:0] ch;
    ch = 8'(Glyphs[$urandom_range(hi, lo)]);
    if (ch >= "a" && ch <= "z" && $urandom_range(1)) ch = ch - 8'd32;
    return ch;
  endfunction

  // a byte that lies in no alphabet: nul, high half, or stray punctuation
  function automatic logic [7:0] pick_foreign();
    case ($urandom_range(4))
      0:       return 8'h00;
      1:       return 8'h80 | 8'($urandom_range(127));
      2:       return " ";
      3:       return "/";
      default: return "^";
    endcase
  endfunction

  // offer one beat, waiting through random sender gaps and any backpressure;
  // called and returns at a falling edge
  task automatic offer_beat(input logic req, input logic [7:0] c0, input logic [7:0] c1,
                            input logic [7:0] c2, input logic [31:0] num);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {num, c2, c1, c0};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic decode_code(input logic [23:0] code);
    offer_beat(tcnc_pkg::ReqDecode, code[23:16], code[15:8], code[7:0], $urandom());
  endtask

  task automatic encode_number(input logic [31:0] num);
    offer_beat(tcnc_pkg::ReqEncode, 8'($urandom()), 8'($urandom()), 8'($urandom()), num);
  endtask

  // random beat: mostly well-formed codes of each class and in-range numbers,
  // the rest bad leads, foreign bytes and numbers in the gaps or far beyond
  task automatic random_beat();
    logic [7:0] c[3];
    int         k;
    if ($urandom_range(1)) begin
      case ($urandom_range(9))
        0, 1: begin
          for (k = 0; k < 3; k++) c[k] = pick_glyph(0, 15);
        end
        2, 3: begin
          c[0] = pick_glyph(16, 35);
          c[1] = pick_glyph(0, 35);
          c[2] = pick_glyph(0, 35);
        end
        4, 5: begin
          c[0] = pick_glyph(36, 40);
          c[1] = pick_glyph(0, 40);
          c[2] = pick_glyph(0, 40);
        end
        6: begin
          // base-36 symbols with a hex lead
          c[0] = pick_glyph(0, 15);
          c[1] = pick_glyph(0, 35);
          c[2] = pick_glyph(0, 35);
        end
        7: begin
          // base-41 symbols with an ordinary lead
          c[0] = pick_glyph(0, 35);
          c[1] = pick_glyph(0, 40);
          c[2] = pick_glyph(0, 40);
        end
        8: begin
          for (k = 0; k < 3; k++) c[k] = 8'($urandom());
        end
        default: begin
          for (k = 0; k < 3; k++) c[k] = pick_glyph(0, 40);
          c[$urandom_range(2)] = pick_foreign();
        end
      endcase
      offer_beat(tcnc_pkg::ReqDecode, c[0], c[1], c[2], $urandom());
    end else begin
      case ($urandom_range(7))
        0:       encode_number($urandom_range(tcnc_pkg::Base36Start - 1, 0));
        1, 2:    encode_number($urandom_range(tcnc_pkg::Base36Last, tcnc_pkg::Base36Start));
        3:       encode_number($urandom_range(tcnc_pkg::Base41Start - 1,
                                              tcnc_pkg::Base36Last + 1));
        4, 5:    encode_number($urandom_range(tcnc_pkg::Base41Last, tcnc_pkg::Base41Start));
        6:       encode_number($urandom_range(65535, tcnc_pkg::Base41Last + 1));
        default: encode_number($urandom());
      endcase
    end
  endtask

  // sender stops until the checker holds no more expectations
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // watchdog: any cycle with a beat on either side restarts the count
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = 1'b0;
    m_tready      = 1'b0;
    hold_req      = 1'b0;
    src_idle_pct  = 16;
    sink_idle_pct = 70;
    rst_ni        = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: hex, base-36 and base-41 extremes, case folding,
    // bad leads, foreign bytes, encode range edges and gaps
    decode_code("000");
    decode_code("fff");
    decode_code("FfF");
    decode_code("g00");
    decode_code("zzz");
    decode_code("ZzZ");
    decode_code("_00");
    decode_code("%%%");
    decode_code("0g0");
    decode_code("0_0");
    decode_code("z_0");
    decode_code(24'h000000);
    decode_code(24'hffffff);
    decode_code("g0 ");
    encode_number(0);
    encode_number(tcnc_pkg::Base36Start - 1);
    encode_number(tcnc_pkg::Base36Start);
    encode_number(tcnc_pkg::Base36Last);
    encode_number(tcnc_pkg::Base36Last + 1);
    encode_number(tcnc_pkg::Base41Start - 1);
    encode_number(tcnc_pkg::Base41Start);
    encode_number(tcnc_pkg::Base41Last);
    encode_number(tcnc_pkg::Base41Last + 1);
    encode_number(32'hffff_ffff);
    drain();

    // sender busy, receiver mostly stalled; one long hold-off fills the block
    for (int i = 0; i < PhaseItems; i++) begin
      if (i == 40) hold_req = 1'b1;
      random_beat();
    end
    drain();

    // the other way round
    src_idle_pct  = 70;
    sink_idle_pct = 16;
    for (int i = 0; i < PhaseItems; i++) random_beat();
    drain();

    // back to back on both sides
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    for (int i = 0; i < PhaseItems; i++) random_beat();
    drain();

    repeat (TailCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ three_char_number_code_converter.f @@
design/tcnc_pkg.sv
design/tcnc_decode.sv
design/tcnc_encode.sv
design/three_char_number_code_converter.sv
design/tcnc_checker.sv
tb/code_conv_checker.sv
tb/testbench.sv
